[design/srtg_pkg.sv]
// ============================================================================
// srtg_pkg
// Shared types and constants of the stepper ramp table generator: field
// widths, clock rate, table geometry, sequencer states, register indexes.
// ============================================================================
`default_nettype none

package srtg_pkg;

    // Build-time constants
    localparam int TABLE_SIZE   = 64;
    localparam int CLOCK_HZ     = 16000000;
    localparam int SEARCH_LIMIT = 4096;

    // Field widths
    localparam int ACC_W  = 24;
    localparam int SPD_W  = 20;
    localparam int IDX_W  = 6;
    localparam int PER_W  = 16;
    localparam int CFG_W  = ACC_W;
    localparam int CIDX_W = 1;

    // Derived widths
    localparam int CLK_W  = $clog2(CLOCK_HZ + 1);
    localparam int TS_W   = $clog2(TABLE_SIZE);
    localparam int D1_W   = ACC_W + TS_W;
    localparam int NUM_W  = SPD_W + CLK_W;
    localparam int DEN_W  = (D1_W > CLK_W) ? D1_W : CLK_W;
    localparam int MUL_AW = (ACC_W > CLK_W) ? ACC_W : CLK_W;
    localparam int Q_W    = SPD_W + 2;
    localparam int ITER_W = $clog2(SEARCH_LIMIT + 1);

    // Lowest speed whose period falls below the saturated value
    localparam int SPEED_MIN = CLOCK_HZ / 65535 + 1;

    localparam logic [PER_W-1:0] PERIOD_MAX = 16'hFFFF;
    localparam logic [CLK_W-1:0] CLK_HZ_V   = CLK_W'(CLOCK_HZ);

    // Configuration register indexes
    typedef enum logic [CIDX_W-1:0] {
        CFG_ACCEL = 1'b0,
        CFG_SPEED = 1'b1
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_X,
        S_DIV_STEP,
        S_MUL_AP,
        S_DIV_AP,
        S_SEARCH,
        S_EMIT,
        S_PREP,
        S_DIV_PER,
        S_ADVANCE
    } t_state;

endpackage

`default_nettype wire

[design/stepper_ramp_table_generator_unit.sv]
// ============================================================================
// stepper_ramp_table_generator_unit
// Builds a linear acceleration ramp as a list of timer periods on request.
// ============================================================================
// A start beat with start_req set produces one ramp table: entry 0 first
// (period 0xFFFF), then one result beat per entry in index order until the
// speed passes speed_limit or the table is full; the final beat carries
// last_entry. A start beat with start_req clear produces nothing. The block
// takes no new start beat until its table is generated. The start-speed
// search runs at most 4096 steps; an entry whose speed is still zero skips
// the division. Setup runs two serial multiplies and two serial divisions;
// each later entry costs one pass of the shared bit-serial divider. Results
// wait in an output register, so a stalled sink does not stop the work on
// the next entry. Configuration writes are always taken and must arrive
// while idle.
// ============================================================================
`default_nettype none

module stepper_ramp_table_generator_unit (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // start channel
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire logic                        i_start_req,
    // result channel
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output logic [srtg_pkg::IDX_W-1:0]       o_entry_index,
    output logic [srtg_pkg::PER_W-1:0]       o_timer_period,
    output logic                             o_last_entry,
    output logic                             o_search_overflow,
    // configuration channel
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [srtg_pkg::CIDX_W-1:0] i_cfg_index,
    input  wire logic [srtg_pkg::CFG_W-1:0]  i_cfg_data
);
    import srtg_pkg::*;

    // Registers
    t_state             r_state, n_state;
    logic [ACC_W-1:0]   r_accel;
    logic [SPD_W-1:0]   r_speed;
    logic [Q_W-1:0]     r_q,     n_q;
    logic [CLK_W-1:0]   r_r,     n_r;
    logic [SPD_W-1:0]   r_aq,    n_aq;
    logic [CLK_W-1:0]   r_ar,    n_ar;
    logic [ITER_W-1:0]  r_iter,  n_iter;
    logic [IDX_W-1:0]   r_idx,   n_idx;
    logic [PER_W-1:0]   r_per,   n_per;
    logic               r_ovf,   n_ovf;
    logic               r_out_valid, n_out_valid;
    logic [IDX_W-1:0]   r_out_idx,   n_out_idx;
    logic [PER_W-1:0]   r_out_per,   n_out_per;
    logic               r_out_last,  n_out_last;
    logic               r_out_ovf,   n_out_ovf;

    // Unit hookup
    logic               mul_start, mul_done;
    logic [MUL_AW-1:0]  mul_a;
    logic [NUM_W-1:0]   mul_b, mul_prod;
    logic               div_start, div_done;
    logic [NUM_W-1:0]   div_num, div_quot;
    logic [DEN_W-1:0]   div_den, div_rem;

    // Misc datapath
    logic [ACC_W-1:0]   acc_eff;
    logic [D1_W-1:0]    d1;
    logic [CLK_W:0]     sum_r, sum_sub;
    logic               carry;
    logic [CLK_W-1:0]   r_new;
    logic [Q_W-1:0]     q_new;
    logic               found;
    logic               last_now;
    logic               out_free;
    logic               in_acc;
    logic [PER_W-1:0]   per_clamp;

    srtg_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    srtg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot),
        .o_rem   (div_rem)
    );

    // Handshake
    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Zero acceleration behaves as one; step divisor is accel * (TABLE_SIZE - 1)
    assign acc_eff = (r_accel == '0) ? ACC_W'(1) : r_accel;
    assign d1      = D1_W'(acc_eff) * D1_W'(TABLE_SIZE - 1);

    // Advance time by one step: speed kept as quotient r_q, remainder r_r of C
    always_comb begin
        sum_r   = {1'b0, r_r} + {1'b0, r_ar};
        carry   = (sum_r >= {1'b0, CLK_HZ_V});
        sum_sub = sum_r - {1'b0, CLK_HZ_V};
        r_new   = carry ? sum_sub[CLK_W-1:0] : sum_r[CLK_W-1:0];
        q_new   = r_q + Q_W'(r_aq) + Q_W'(carry);
    end

    assign found     = (r_q >= Q_W'(SPEED_MIN));
    assign last_now  = (r_idx == IDX_W'(TABLE_SIZE - 1)) || (r_q > Q_W'(r_speed));
    assign per_clamp = (div_quot > NUM_W'(PERIOD_MAX)) ? PERIOD_MAX : div_quot[PER_W-1:0];

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_q         = r_q;
        n_r         = r_r;
        n_aq        = r_aq;
        n_ar        = r_ar;
        n_iter      = r_iter;
        n_idx       = r_idx;
        n_per       = r_per;
        n_ovf       = r_ovf;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_idx   = r_out_idx;
        n_out_per   = r_out_per;
        n_out_last  = r_out_last;
        n_out_ovf   = r_out_ovf;
        mul_start   = 1'b0;
        mul_a       = '0;
        mul_b       = '0;
        div_start   = 1'b0;
        div_num     = '0;
        div_den     = '0;

        case (r_state)
            S_IDLE: begin
                mul_a = MUL_AW'(CLK_HZ_V);
                mul_b = NUM_W'(r_speed);
                if (in_acc && i_start_req) begin
                    mul_start = 1'b1;
                    n_q       = '0;
                    n_r       = '0;
                    n_iter    = '0;
                    n_state   = S_MUL_X;
                end
            end
            // speed_limit * C done: divide by accel * (TABLE_SIZE - 1)
            S_MUL_X: begin
                div_num = mul_prod;
                div_den = DEN_W'(d1);
                if (mul_done) begin
                    div_start = 1'b1;
                    n_state   = S_DIV_STEP;
                end
            end
            // time step done: speed increment numerator accel * step
            S_DIV_STEP: begin
                mul_a = MUL_AW'(acc_eff);
                mul_b = div_quot;
                if (div_done) begin
                    mul_start = 1'b1;
                    n_state   = S_MUL_AP;
                end
            end
            S_MUL_AP: begin
                div_num = mul_prod;
                div_den = DEN_W'(CLK_HZ_V);
                if (mul_done) begin
                    div_start = 1'b1;
                    n_state   = S_DIV_AP;
                end
            end
            S_DIV_AP: begin
                if (div_done) begin
                    n_aq    = div_quot[SPD_W-1:0];
                    n_ar    = div_rem[CLK_W-1:0];
                    n_state = S_SEARCH;
                end
            end
            // start-speed search; it stops without advancing, so entry 1 takes the found speed
            S_SEARCH: begin
                if (found || (r_iter == ITER_W'(SEARCH_LIMIT))) begin
                    n_ovf   = !found;
                    n_idx   = '0;
                    n_per   = PERIOD_MAX;
                    n_state = S_EMIT;
                end else begin
                    n_q    = q_new;
                    n_r    = r_new;
                    n_iter = r_iter + ITER_W'(1);
                end
            end
            // r_q already holds the next entry's speed
            S_EMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_idx   = r_idx;
                    n_out_per   = r_per;
                    n_out_last  = last_now;
                    n_out_ovf   = r_ovf;
                    if (last_now) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + IDX_W'(1);
                        n_state = S_PREP;
                    end
                end
            end
            // zero speed keeps the previous period
            S_PREP: begin
                div_num = NUM_W'(CLK_HZ_V);
                div_den = DEN_W'(r_q);
                if (r_q != '0) begin
                    div_start = 1'b1;
                    n_state   = S_DIV_PER;
                end else begin
                    n_state = S_ADVANCE;
                end
            end
            S_DIV_PER: begin
                if (div_done) begin
                    n_per   = per_clamp;
                    n_state = S_ADVANCE;
                end
            end
            S_ADVANCE: begin
                n_q     = q_new;
                n_r     = r_new;
                n_state = S_EMIT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_accel     <= ACC_W'(1000);
            r_speed     <= SPD_W'(1000);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_ACCEL: r_accel <= i_cfg_data[ACC_W-1:0];
                    CFG_SPEED: r_speed <= i_cfg_data[SPD_W-1:0];
                    default:   r_accel <= r_accel;
                endcase
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_q        <= n_q;
        r_r        <= n_r;
        r_aq       <= n_aq;
        r_ar       <= n_ar;
        r_iter     <= n_iter;
        r_idx      <= n_idx;
        r_per      <= n_per;
        r_ovf      <= n_ovf;
        r_out_idx  <= n_out_idx;
        r_out_per  <= n_out_per;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    assign o_out_valid       = r_out_valid;
    assign o_entry_index     = r_out_idx;
    assign o_timer_period    = r_out_per;
    assign o_last_entry      = r_out_last;
    assign o_search_overflow = r_out_ovf;

`ifndef SYNTH
    // The top table position always closes the table
    a_last_at_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_entry_index == IDX_W'(TABLE_SIZE - 1)) |-> o_last_entry)
        else $error("top table entry not marked last");

    // An entry is only built when its speed is within the limit
    a_prep_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PREP) |-> (r_q <= Q_W'(r_speed)))
        else $error("entry built past speed limit");

    // The search never runs past its cap
    a_search_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> (r_iter <= ITER_W'(SEARCH_LIMIT)))
        else $error("search step count past cap");
`endif

endmodule

`default_nettype wire

[design/srtg_div.sv]
// ============================================================================
// srtg_div
// Bit-serial restoring divider: one quotient bit per cycle.
// Quotient and remainder hold until the next start.
// ============================================================================
`default_nettype none

module srtg_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [srtg_pkg::NUM_W-1:0] i_num,
    input  wire logic [srtg_pkg::DEN_W-1:0] i_den,
    output logic                            o_done,
    output logic [srtg_pkg::NUM_W-1:0]      o_quot,
    output logic [srtg_pkg::DEN_W-1:0]      o_rem
);
    import srtg_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt,  n_cnt;
    logic [NUM_W-1:0] r_num,  n_num;
    logic [DEN_W-1:0] r_den,  n_den;
    logic [DEN_W-1:0] r_rem,  n_rem;

    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             ge;

    // One restoring step: shift in the next dividend bit, try the subtract
    always_comb begin
        rem_sh  = {r_rem, r_num[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        ge      = (rem_sh >= {1'b0, r_den});
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_den  = r_den;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(NUM_W - 1);
            n_num  = i_num;
            n_den  = i_den;
            n_rem  = '0;
        end else if (r_busy) begin
            n_num = {r_num[NUM_W-2:0], ge};
            n_rem = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_num <= n_num;
        r_den <= n_den;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_quot = r_num;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

[design/srtg_mul.sv]
// ============================================================================
// srtg_mul
// Bit-serial shift-and-add multiplier, multiplier bits taken MSB first,
// one per cycle. The product must fit NUM_W bits.
// ============================================================================
`default_nettype none

module srtg_mul (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [srtg_pkg::MUL_AW-1:0] i_a,
    input  wire logic [srtg_pkg::NUM_W-1:0]  i_b,
    output logic                             o_done,
    output logic [srtg_pkg::NUM_W-1:0]       o_prod
);
    import srtg_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt,  n_cnt;
    logic [MUL_AW-1:0] r_a,    n_a;
    logic [NUM_W-1:0]  r_b,    n_b;
    logic [NUM_W-1:0]  r_prod, n_prod;

    // Partial products never exceed the final one, so no wrap occurs
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_prod = r_prod;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(NUM_W - 1);
            n_a    = i_a;
            n_b    = i_b;
            n_prod = '0;
        end else if (r_busy) begin
            n_prod = (r_prod << 1) + (r_b[NUM_W-1] ? NUM_W'(r_a) : '0);
            n_b    = r_b << 1;
            n_cnt  = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_a    <= n_a;
        r_b    <= n_b;
        r_prod <= n_prod;
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

`default_nettype wire

[tb/ramp_table_checker.sv]
`timescale 1ns / 1ps
// ============================================================================
// ramp_table_checker
// Watches the start, result and configuration channels of the ramp table
// generator, predicts every table entry from its own copy of the registers,
// and compares each accepted result beat field by field, in order.
// ============================================================================

module ramp_table_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // start channel
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_stall,
    input  wire logic                          i_start_req,
    // result channel
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_stall,
    input  wire logic [srtg_pkg::IDX_W-1:0]    i_entry_index,
    input  wire logic [srtg_pkg::PER_W-1:0]    i_timer_period,
    input  wire logic                          i_last_entry,
    input  wire logic                          i_search_overflow,
    // configuration channel
    input  wire logic                          i_cfg_valid,
    input  wire logic                          i_cfg_ready,
    input  wire logic [srtg_pkg::CIDX_W-1:0]   i_cfg_index,
    input  wire logic [srtg_pkg::CFG_W-1:0]    i_cfg_data,
    // status toward the testbench top
    output int                                 o_mismatches,
    output int                                 o_pending,
    output int                                 o_checked,
    output int                                 o_capped
);
    import srtg_pkg::*;

    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [PER_W-1:0] period;
        logic             is_last;
        logic             capped;
    } t_ramp_entry;

    t_ramp_entry      ramp_entries_q[$];
    logic [ACC_W-1:0] accel_setting;
    logic [SPD_W-1:0] speed_setting;
    int               mismatches = 0;
    int               checked    = 0;
    int               capped     = 0;

    // One line per mismatch, printing stops after a cap but counting does not
    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < PRINT_CAP)
            $display("ERROR %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    // floor(ap*k / CLOCK_HZ), split so the product never overflows
    function automatic longint unsigned speed_at_step(input longint unsigned ap,
                                                      input longint unsigned k);
        longint unsigned q;
        longint unsigned r;
        q = ap / 64'(CLOCK_HZ);
        r = ap % 64'(CLOCK_HZ);
        return k * q + (k * r) / 64'(CLOCK_HZ);
    endfunction

    // Timer period for a nonzero speed, saturated
    function automatic logic [PER_W-1:0] period_for(input longint unsigned spd);
        longint unsigned p;
        p = 64'(CLOCK_HZ) / spd;
        return (p > 64'(PERIOD_MAX)) ? PERIOD_MAX : p[PER_W-1:0];
    endfunction

    // Expected table for one ramp request, appended to the entry store
    function automatic void build_ramp(input logic [ACC_W-1:0] acc_reg,
                                       input logic [SPD_W-1:0] spd_reg);
        longint unsigned acc;
        longint unsigned tstep;
        longint unsigned ap;
        longint unsigned k;
        longint unsigned spd;
        logic [PER_W-1:0] per;
        logic             ovf;
        int               iter;
        t_ramp_entry      held;

        acc   = (acc_reg == '0) ? 64'd1 : 64'(acc_reg);
        tstep = 64'(spd_reg) * 64'(CLOCK_HZ) / acc / 64'(TABLE_SIZE - 1);
        ap    = acc * tstep;

        // start-speed search: first step whose period leaves saturation
        k    = 0;
        per  = PERIOD_MAX;
        iter = 0;
        while (per == PERIOD_MAX && iter < SEARCH_LIMIT) begin
            iter++;
            k++;
            spd = speed_at_step(ap, k);
            if (spd > 0)
                per = period_for(spd);
        end
        ovf = (per == PERIOD_MAX);
        if (k > 0)
            k--;
        if (ovf)
            capped++;

        // entry 0 is always saturated; hold each entry until the next exists
        held = '{index: '0, period: PERIOD_MAX, is_last: 1'b0, capped: ovf};
        for (int i = 1; i < TABLE_SIZE; i++) begin
            k++;
            spd = speed_at_step(ap, k);
            if (spd > 64'(spd_reg))
                break;
            if (spd > 0)
                per = period_for(spd);
            ramp_entries_q.push_back(held);
            held = '{index: IDX_W'(i), period: per, is_last: 1'b0, capped: ovf};
        end
        held.is_last = 1'b1;
        ramp_entries_q.push_back(held);
    endfunction

    // Compare one result beat against the oldest expected entry
    task automatic check_entry();
        t_ramp_entry want;
        if (ramp_entries_q.size() == 0) begin
            report_mismatch("result beat with no entry pending, index", i_entry_index, -1);
        end else begin
            want = ramp_entries_q.pop_front();
            checked++;
            if (i_entry_index !== want.index)
                report_mismatch("entry_index", i_entry_index, want.index);
            if (i_timer_period !== want.period)
                report_mismatch($sformatf("timer_period at entry %0d", want.index),
                                i_timer_period, want.period);
            if (i_last_entry !== want.is_last)
                report_mismatch($sformatf("last_entry at entry %0d", want.index),
                                i_last_entry, want.is_last);
            if (i_search_overflow !== want.capped)
                report_mismatch($sformatf("search_overflow at entry %0d", want.index),
                                i_search_overflow, want.capped);
        end
    endtask

    // Channel monitor: results are checked before a new request is predicted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            accel_setting = ACC_W'(1000);
            speed_setting = SPD_W'(1000);
            ramp_entries_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_ACCEL)
                    accel_setting = i_cfg_data[ACC_W-1:0];
                else
                    speed_setting = i_cfg_data[SPD_W-1:0];
            end
            if (i_out_valid && !i_out_stall)
                check_entry();
            if (i_in_valid && !i_in_stall && i_start_req)
                build_ramp(accel_setting, speed_setting);
        end
        o_mismatches <= mismatches;
        o_pending    <= ramp_entries_q.size();
        o_checked    <= checked;
        o_capped     <= capped;
    end

endmodule

[tb/tb_stepper_ramp_table_generator_unit.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb_stepper_ramp_table_generator_unit
// Drives ramp requests and register settings into the ramp table generator
// under random start and result idling, then gives the verdict from the
// checker's mismatch count.
// ============================================================================

module tb_stepper_ramp_table_generator_unit;
    import srtg_pkg::*;

    localparam int     RANDOM_RAMPS = 70;
    localparam int     DRAIN_CYCLES = 250;   // covers the tail of an empty request
    localparam int     HOLD_CYCLES  = 1500;
    localparam longint TIMEOUT_NS   = 40_000_000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic              start_req;
    logic              out_valid;
    logic              out_stall;
    logic [IDX_W-1:0]  entry_index;
    logic [PER_W-1:0]  timer_period;
    logic              last_entry;
    logic              search_overflow;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CIDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]  cfg_data;

    int mismatches;
    int pending;
    int checked;
    int capped;

    int ramps_sent   = 0;
    int empty_sent   = 0;
    int writes_done  = 0;
    bit tx_burst     = 1'b0;
    bit rx_burst     = 1'b0;
    bit hold_pending = 1'b0;

    stepper_ramp_table_generator_unit DUT (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_start_req       (start_req),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_entry_index     (entry_index),
        .o_timer_period    (timer_period),
        .o_last_entry      (last_entry),
        .o_search_overflow (search_overflow),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    ramp_table_checker u_ramp_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_start_req       (start_req),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_entry_index     (entry_index),
        .i_timer_period    (timer_period),
        .i_last_entry      (last_entry),
        .i_search_overflow (search_overflow),
        .i_cfg_valid       (cfg_valid),
        .i_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_mismatches      (mismatches),
        .o_pending         (pending),
        .o_checked         (checked),
        .o_capped          (capped)
    );

    // 100 MHz clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial begin
        #(TIMEOUT_NS);
        $display("stepper_ramp_table_generator_unit verification failed");
        $finish;
    end

    // Result sink: random stall per beat, plus one long hold on request
    initial begin : result_sink
        int stall_wait;
        int hold_left;
        stall_wait = 0;
        hold_left  = 0;
        out_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else begin
                if (out_valid && !out_stall)
                    stall_wait = rx_burst ? 0 : $urandom_range(0, 4);
                if (stall_wait != 0) begin
                    stall_wait--;
                    out_stall <= 1'b1;
                end else begin
                    out_stall <= 1'b0;
                end
            end
        end
    end

    // Random value of up to w bits, log spread, never zero
    function automatic logic [31:0] rand_bits(input int w);
        int          n;
        logic [31:0] v;
        n = $urandom_range(1, w);
        v = $urandom & ((32'd1 << n) - 32'd1);
        return (v == 0) ? 32'd1 : v;
    endfunction

    // Offer one start beat after a random gap and wait until it is taken
    task automatic offer_start(input logic req);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        start_req <= req;
        do @(posedge clk); while (in_stall);
        if (req)
            ramps_sent++;
        else
            empty_sent++;
    endtask

    // A batch of ramp and empty requests in random order
    task automatic send_batch(input int n_ramps, input int n_empty);
        int  ramps_left;
        int  empty_left;
        logic req;
        ramps_left = n_ramps;
        empty_left = n_empty;
        while (ramps_left + empty_left != 0) begin
            if (ramps_left == 0)
                req = 1'b0;
            else if (empty_left == 0)
                req = 1'b1;
            else
                req = ($urandom_range(0, ramps_left + empty_left - 1) < ramps_left);
            offer_start(req);
            if (req)
                ramps_left--;
            else
                empty_left--;
        end
        in_valid <= 1'b0;
    endtask

    // Block is idle once every entry is in and the tail has passed;
    // the pending count is a registered copy of the checker's entry store size
    task automatic wait_idle();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        writes_done++;
    endtask

    // New acceleration and top speed, written only while idle
    task automatic load_setup(input logic [CFG_W-1:0] accel, input logic [CFG_W-1:0] speed);
        wait_idle();
        write_reg(CFG_ACCEL, accel);
        write_reg(CFG_SPEED, speed);
        cfg_valid <= 1'b0;
    endtask

    // Stimulus and verdict
    initial begin : stimulus
        int          random_ramps;
        logic [31:0] accel_word;
        logic [31:0] speed_word;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        start_req <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_ACCEL;
        cfg_data  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, two ramps and an empty request in random order
        send_batch(2, 1);
        // both registers at full scale, upper speed bits set and ignored
        load_setup(24'hFFFFFF, 24'hFFFFFF);
        send_batch(1, 0);
        // slowest ramp: search runs into its cap, table is entry 0 only
        load_setup(24'd1, 24'd1);
        send_batch(1, 1);
        // zero acceleration acts as one
        load_setup(24'd0, 24'h0FFFFF);
        send_batch(1, 0);
        // time step truncates to zero: capped search, all periods saturated
        load_setup(24'hFFFFFF, 24'd1);
        send_batch(1, 0);
        // shortest start search at the highest speed
        load_setup(24'd1, 24'h0FFFFF);
        send_batch(1, 0);
        // long sink hold while requests keep coming, back to back
        load_setup(24'd5000, 24'd20000);
        tx_burst     = 1'b1;
        hold_pending = 1'b1;
        send_batch(3, 1);

        // random settings, a few requests per setting
        random_ramps = 0;
        while (random_ramps < RANDOM_RAMPS) begin
            int n;
            accel_word = rand_bits(ACC_W);
            // junk in the unused upper speed bits
            speed_word = rand_bits(SPD_W) | (32'($urandom_range(0, 15)) << SPD_W);
            load_setup(accel_word[CFG_W-1:0], speed_word[CFG_W-1:0]);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            n = $urandom_range(1, 4);
            send_batch(n, $urandom_range(0, 1));
            random_ramps += n;
        end

        wait_idle();
        $display("Run covered %0d ramp requests and %0d empty requests over %0d register writes",
                 ramps_sent, empty_sent, writes_done);
        $display("Checked %0d table entries; %0d tables came from a capped start search",
                 checked, capped);
        if (mismatches == 0 && pending == 0)
            $display("stepper_ramp_table_generator_unit verification clean");
        else
            $display("stepper_ramp_table_generator_unit verification failed");
        $finish;
    end

endmodule
